// ===== rtl/core/ssap_pkg.sv =====
// shared types and constants of the sparse set active partition
`timescale 1ns / 1ps
`default_nettype none

package ssap_pkg;

  localparam int unsigned MAX_ARCS_DEF    = 64;
  localparam int unsigned STAMP_BITS_DEF  = 32;
  localparam int unsigned ARC_COUNT_RESET = 64;

  // operation codes carried in the command field
  typedef enum logic [2:0] {
    CMD_QUERY      = 3'd0,
    CMD_ACTIVATE   = 3'd1,
    CMD_DEACTIVATE = 3'd2,
    CMD_CLEAR_ALL  = 3'd3,
    CMD_COMMIT     = 3'd4
  } cmd_e;

  // kinds of table write
  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_INIT   = 2'd1,
    WR_TENT   = 2'd2,
    WR_COMMIT = 2'd3
  } wr_kind_e;

  typedef struct packed {
    logic     rd_en;
    wr_kind_e wr_kind;
  } tbl_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/ssap_table.sv =====
// one stamped table: committed value, tentative value, stamp and stamp valid per entry
`timescale 1ns / 1ps
`default_nettype none

module ssap_table #(
  parameter int unsigned DEPTH      = ssap_pkg::MAX_ARCS_DEF,
  parameter int unsigned IDX_W      = 6,
  parameter int unsigned STAMP_BITS = ssap_pkg::STAMP_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire ssap_pkg::tbl_ctl_t    ctl_i,
  input  wire logic [IDX_W-1:0]      rd_addr_i,
  input  wire logic [IDX_W-1:0]      wr_addr_i,
  input  wire logic [IDX_W-1:0]      wr_val_i,
  input  wire logic [IDX_W-1:0]      wr_comm_i,
  input  wire logic [STAMP_BITS-1:0] stamp_i,
  output logic      [IDX_W-1:0]      view_o,
  output logic      [IDX_W-1:0]      comm_o
);

  typedef struct packed {
    logic                  sv;
    logic [STAMP_BITS-1:0] stamp;
    logic [IDX_W-1:0]      tent;
    logic [IDX_W-1:0]      comm;
  } entry_t;

  entry_t mem_q [DEPTH];
  entry_t rd_q;
  entry_t wr_word;
  logic   hit;
  logic   wr_en;

  // tentative value wins when stamped with the current timestamp
  assign hit    = rd_q.sv && (rd_q.stamp == stamp_i);
  assign view_o = hit ? rd_q.tent : rd_q.comm;
  assign comm_o = rd_q.comm;

  always_comb begin
    wr_word = rd_q;
    wr_en   = 1'b0;
    unique case (ctl_i.wr_kind)
      ssap_pkg::WR_INIT: begin
        wr_word = '{sv: 1'b0, stamp: '0, tent: '0, comm: wr_val_i};
        wr_en   = 1'b1;
      end
      ssap_pkg::WR_TENT: begin
        wr_word = '{sv: 1'b1, stamp: stamp_i, tent: wr_val_i, comm: wr_comm_i};
        wr_en   = 1'b1;
      end
      ssap_pkg::WR_COMMIT: begin
        // rd_q holds the entry at wr_addr_i, read in the previous cycle
        wr_word.comm = rd_q.tent;
        wr_en        = hit;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_q <= mem_q[rd_addr_i];
    end
    if (wr_en) begin
      mem_q[wr_addr_i] <= wr_word;
    end
  end

  // reads never land on the entry written in the same cycle
  assert property (@(posedge clk_i) (ctl_i.rd_en && wr_en) |-> (rd_addr_i != wr_addr_i))
    else $error("table read and write collide on one entry");

endmodule

`default_nettype wire

// ===== rtl/core/sparse_set_active_partition.sv =====
// top level of the sparse set active partition with timestamped tentative writes
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: command, arc_index, timestamp
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: is_active, active_count
//                                               tuser: bad_index
//  cfg       in   cfg_we_i (no wait)           cfg_wdata_i: arc_count
//
//  states: query, clear all and ignored operations go from look straight to done,
//    an activate or deactivate that swaps passes swap1 and swap2 (two reads then two writes
//    per table, one port each), commit sweeps all entries, one a cycle through both tables
//  reset: a clearing pass writes the identity permutation into both tables; no
//    transaction is taken on s_axis until it ends, config writes are taken
//  stalls: one item is worked on at a time; a finished result sits in the output
//    register while the next item is accepted and processed up to its result
`timescale 1ns / 1ps
`default_nettype none

module sparse_set_active_partition #(
  parameter int unsigned MAX_ARCS   = ssap_pkg::MAX_ARCS_DEF,
  parameter int unsigned STAMP_BITS = ssap_pkg::STAMP_BITS_DEF,
  localparam int unsigned IDX_W     = $clog2(MAX_ARCS),
  localparam int unsigned CNT_W     = $clog2(MAX_ARCS + 1),
  localparam int unsigned IN_W      = ((3 + IDX_W + STAMP_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W     = ((1 + CNT_W + 7) / 8) * 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // command [2:0], arc_index, timestamp, zero fill
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // is_active [0], active_count, zero fill
  output logic      [OUT_W-1:0] m_axis_tdata,
  // bad_index [0]
  output logic                  m_axis_tuser,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  input  wire logic             cfg_we_i,
  input  wire logic [CNT_W-1:0] cfg_wdata_i
);

  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_ARCS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ARCS - 1);
  localparam logic [CNT_W-1:0] ARC_RST  = (ssap_pkg::ARC_COUNT_RESET > MAX_ARCS) ?
                                          CNT_W'(MAX_ARCS) :
                                          CNT_W'(ssap_pkg::ARC_COUNT_RESET);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_SWAP1,
    ST_SWAP2,
    ST_COMMIT,
    ST_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic [CNT_W-1:0] arc_count_q;

  // count state, kept in flops
  logic [CNT_W-1:0]      cnt_comm_q;
  logic [CNT_W-1:0]      cnt_tent_q;
  logic [STAMP_BITS-1:0] cnt_stamp_q;
  logic                  cnt_sv_q;

  // item held while it is worked on
  ssap_pkg::cmd_e        cmd_q;
  logic [IDX_W-1:0]      a_q;        // clipped arc address
  logic [STAMP_BITS-1:0] ts_q;
  logic                  valid_q;
  logic [CNT_W-1:0]      c_q;        // count seen at the timestamp
  logic [CNT_W-1:0]      pb_q;       // boundary position
  logic [IDX_W-1:0]      pa_q;
  logic [IDX_W-1:0]      b_q;
  logic [IDX_W-1:0]      pos_a_comm_q;
  logic [IDX_W-1:0]      pos_b_comm_q;
  logic [IDX_W-1:0]      mem_pb_comm_q;
  logic [CNT_W-1:0]      rp_q;       // sweep pointer for clearing pass and commit

  // result and output register
  logic             res_act_q;
  logic [CNT_W-1:0] res_cnt_q;
  logic             res_bad_q;
  logic             out_valid_q;
  logic             out_act_q;
  logic [CNT_W-1:0] out_cnt_q;
  logic             out_bad_q;

  // input fields
  ssap_pkg::cmd_e        in_cmd;
  logic [IDX_W-1:0]      in_arc;
  logic [STAMP_BITS-1:0] in_ts;
  logic                  accept;
  logic [CNT_W-1:0]      in_c;
  logic [CNT_W-1:0]      in_pb;
  logic [IDX_W-1:0]      in_a_addr;
  logic [IDX_W-1:0]      in_pb_addr;

  // table ports
  ssap_pkg::tbl_ctl_t pos_ctl;
  ssap_pkg::tbl_ctl_t mem_ctl;
  logic [IDX_W-1:0]   pos_rd_addr, pos_wr_addr, pos_wr_val, pos_wr_comm;
  logic [IDX_W-1:0]   mem_rd_addr, mem_wr_addr, mem_wr_val, mem_wr_comm;
  logic [STAMP_BITS-1:0] tbl_stamp;
  logic [IDX_W-1:0]   pos_view, pos_comm;
  logic [IDX_W-1:0]   mem_view, mem_comm;

  // decision made once both first reads are back
  logic             is_act;
  logic             is_deact;
  logic             do_move;
  logic             swap;
  logic             cnt_write;
  logic [CNT_W-1:0] cnt_new;
  logic [IDX_W-1:0] pa_final;
  logic             res_act;
  logic             res_bad;
  logic             cnt_hit;

  assign in_cmd = ssap_pkg::cmd_e'(s_axis_tdata[2:0]);
  assign in_arc = s_axis_tdata[3 +: IDX_W];
  assign in_ts  = s_axis_tdata[3 + IDX_W +: STAMP_BITS];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // count as seen by the incoming timestamp
  assign in_c  = (cnt_sv_q && (cnt_stamp_q == in_ts)) ? cnt_tent_q : cnt_comm_q;
  // activate swaps to the current count, deactivate to the count after shrinking
  assign in_pb = (in_cmd == ssap_pkg::CMD_ACTIVATE) ? in_c : in_c - CNT_W'(1);

  // out of range addresses clip to the last entry, as in the ignored cases
  assign in_a_addr  = (CNT_W'(in_arc) < MAX_CNT) ? in_arc : LAST_IDX;
  assign in_pb_addr = (in_pb < MAX_CNT) ? in_pb[IDX_W-1:0] : LAST_IDX;

  assign cnt_hit   = cnt_sv_q && (cnt_stamp_q == ts_q);
  assign tbl_stamp = (state_q == ST_IDLE) ? in_ts : ts_q;

  // decision logic for the look state
  always_comb begin
    is_act   = (cmd_q == ssap_pkg::CMD_ACTIVATE);
    is_deact = (cmd_q == ssap_pkg::CMD_DEACTIVATE);
    do_move  = valid_q && ((is_act && (CNT_W'(pos_view) >= c_q)) ||
                           (is_deact && (CNT_W'(pos_view) < c_q)));
    swap     = do_move && (CNT_W'(pos_view) != pb_q) && (pb_q < MAX_CNT);
    priority if (do_move && is_act) begin
      cnt_new = (c_q >= MAX_CNT) ? MAX_CNT : c_q + CNT_W'(1);
    end else if (do_move && is_deact) begin
      cnt_new = c_q - CNT_W'(1);
    end else if (cmd_q == ssap_pkg::CMD_CLEAR_ALL) begin
      cnt_new = '0;
    end else begin
      cnt_new = c_q;
    end
    cnt_write = do_move || (cmd_q == ssap_pkg::CMD_CLEAR_ALL);
    // when the boundary arc is the addressed arc, the later write leaves pa in place
    pa_final  = (swap && (a_q != mem_view)) ? pb_q[IDX_W-1:0] : pos_view;
    res_act   = valid_q && (CNT_W'(pa_final) < cnt_new);
    res_bad   = !valid_q && (cmd_q == ssap_pkg::CMD_QUERY || is_act || is_deact);
  end

  // table port steering
  always_comb begin
    pos_ctl.rd_en   = 1'b0;
    pos_ctl.wr_kind = ssap_pkg::WR_NONE;
    mem_ctl.rd_en   = 1'b0;
    mem_ctl.wr_kind = ssap_pkg::WR_NONE;
    pos_rd_addr     = in_a_addr;
    mem_rd_addr     = in_pb_addr;
    pos_wr_addr     = a_q;
    mem_wr_addr     = pa_q;
    pos_wr_val      = pb_q[IDX_W-1:0];
    mem_wr_val      = b_q;
    pos_wr_comm     = pos_a_comm_q;
    mem_wr_comm     = mem_comm;
    unique case (state_q)
      ST_INIT: begin
        pos_ctl.wr_kind = ssap_pkg::WR_INIT;
        mem_ctl.wr_kind = ssap_pkg::WR_INIT;
        pos_wr_addr     = rp_q[IDX_W-1:0];
        mem_wr_addr     = rp_q[IDX_W-1:0];
        pos_wr_val      = rp_q[IDX_W-1:0];
        mem_wr_val      = rp_q[IDX_W-1:0];
      end
      ST_IDLE: begin
        // position of the arc and the arc at the boundary
        pos_ctl.rd_en = accept;
        mem_ctl.rd_en = accept;
      end
      ST_LOOK: begin
        // position of the boundary arc and the arc at the old position
        pos_ctl.rd_en = swap;
        mem_ctl.rd_en = swap;
        pos_rd_addr   = mem_view;
        mem_rd_addr   = pos_view;
      end
      ST_SWAP1: begin
        // member[pa] = b, position[a] = pb
        pos_ctl.wr_kind = ssap_pkg::WR_TENT;
        mem_ctl.wr_kind = ssap_pkg::WR_TENT;
      end
      ST_SWAP2: begin
        // member[pb] = a, position[b] = pa
        pos_ctl.wr_kind = ssap_pkg::WR_TENT;
        mem_ctl.wr_kind = ssap_pkg::WR_TENT;
        pos_wr_addr     = b_q;
        pos_wr_val      = pa_q;
        pos_wr_comm     = pos_b_comm_q;
        mem_wr_addr     = pb_q[IDX_W-1:0];
        mem_wr_val      = a_q;
        mem_wr_comm     = mem_pb_comm_q;
      end
      ST_COMMIT: begin
        // read entry rp while the entry before it is committed
        pos_ctl.rd_en = (rp_q < MAX_CNT);
        mem_ctl.rd_en = (rp_q < MAX_CNT);
        pos_rd_addr   = rp_q[IDX_W-1:0];
        mem_rd_addr   = rp_q[IDX_W-1:0];
        pos_wr_addr   = IDX_W'(rp_q - CNT_W'(1));
        mem_wr_addr   = IDX_W'(rp_q - CNT_W'(1));
        if (rp_q != '0) begin
          pos_ctl.wr_kind = ssap_pkg::WR_COMMIT;
          mem_ctl.wr_kind = ssap_pkg::WR_COMMIT;
        end
      end
      ST_DONE: begin
        pos_ctl.rd_en = 1'b0;
      end
      default: begin
        pos_ctl.rd_en = 1'b0;
      end
    endcase
  end

  ssap_table #(
    .DEPTH      (MAX_ARCS),
    .IDX_W      (IDX_W),
    .STAMP_BITS (STAMP_BITS)
  ) u_pos_table (
    .clk_i     (clk_i),
    .ctl_i     (pos_ctl),
    .rd_addr_i (pos_rd_addr),
    .wr_addr_i (pos_wr_addr),
    .wr_val_i  (pos_wr_val),
    .wr_comm_i (pos_wr_comm),
    .stamp_i   (tbl_stamp),
    .view_o    (pos_view),
    .comm_o    (pos_comm)
  );

  ssap_table #(
    .DEPTH      (MAX_ARCS),
    .IDX_W      (IDX_W),
    .STAMP_BITS (STAMP_BITS)
  ) u_mem_table (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .rd_addr_i (mem_rd_addr),
    .wr_addr_i (mem_wr_addr),
    .wr_val_i  (mem_wr_val),
    .wr_comm_i (mem_wr_comm),
    .stamp_i   (tbl_stamp),
    .view_o    (mem_view),
    .comm_o    (mem_comm)
  );

  // configuration register, oversized writes saturate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arc_count_q <= ARC_RST;
    end else if (cfg_we_i) begin
      arc_count_q <= (cfg_wdata_i > MAX_CNT) ? MAX_CNT : cfg_wdata_i;
    end
  end

  // sequencer, count state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_INIT;
      rp_q          <= '0;
      cnt_comm_q    <= '0;
      cnt_tent_q    <= '0;
      cnt_stamp_q   <= '0;
      cnt_sv_q      <= 1'b0;
      cmd_q         <= ssap_pkg::CMD_QUERY;
      a_q           <= '0;
      ts_q          <= '0;
      valid_q       <= 1'b0;
      c_q           <= '0;
      pb_q          <= '0;
      pa_q          <= '0;
      b_q           <= '0;
      pos_a_comm_q  <= '0;
      pos_b_comm_q  <= '0;
      mem_pb_comm_q <= '0;
      res_act_q     <= 1'b0;
      res_cnt_q     <= '0;
      res_bad_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      out_act_q     <= 1'b0;
      out_cnt_q     <= '0;
      out_bad_q     <= 1'b0;
    end else begin
      // the done state reloads the output register itself
      if (out_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_INIT: begin
          rp_q <= rp_q + CNT_W'(1);
          if (rp_q == CNT_W'(MAX_ARCS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cmd_q   <= in_cmd;
            a_q     <= in_a_addr;
            ts_q    <= in_ts;
            valid_q <= (CNT_W'(in_arc) < arc_count_q);
            c_q     <= in_c;
            pb_q    <= in_pb;
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          pa_q          <= pos_view;
          b_q           <= mem_view;
          pos_a_comm_q  <= pos_comm;
          mem_pb_comm_q <= mem_comm;
          res_act_q     <= res_act;
          res_cnt_q     <= cnt_new;
          res_bad_q     <= res_bad;
          if (cnt_write) begin
            cnt_tent_q  <= cnt_new;
            cnt_stamp_q <= ts_q;
            cnt_sv_q    <= 1'b1;
          end
          // commit leaves the view at its own timestamp unchanged
          if (cmd_q == ssap_pkg::CMD_COMMIT && cnt_hit) begin
            cnt_comm_q <= cnt_tent_q;
          end
          rp_q <= '0;
          priority if (swap) begin
            state_q <= ST_SWAP1;
          end else if (cmd_q == ssap_pkg::CMD_COMMIT) begin
            state_q <= ST_COMMIT;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_SWAP1: begin
          pos_b_comm_q <= pos_comm;
          state_q      <= ST_SWAP2;
        end
        ST_SWAP2: begin
          state_q <= ST_DONE;
        end
        ST_COMMIT: begin
          rp_q <= rp_q + CNT_W'(1);
          if (rp_q == MAX_CNT) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_act_q   <= res_act_q;
            out_cnt_q   <= res_cnt_q;
            out_bad_q   <= res_bad_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_cnt_q, out_act_q});
  assign m_axis_tuser  = out_bad_q;

  // a flagged index never reports an active arc
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (m_axis_tvalid && m_axis_tuser) |-> !m_axis_tdata[0])
    else $error("bad index reported as active");

  // the committed and tentative counts stay within the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cnt_comm_q <= MAX_CNT) && (!cnt_sv_q || cnt_tent_q <= MAX_CNT))
    else $error("active count beyond table depth");

  // a swap only starts from a boundary inside the table and away from the arc
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == ST_SWAP1) |-> ((pb_q < MAX_CNT) && (CNT_W'(pa_q) != pb_q)))
    else $error("swap started with an illegal boundary");

  // a held result is never overwritten before it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) &&
                   $stable(m_axis_tuser)))
    else $error("pending result changed under stall");

endmodule

`default_nettype wire

// ===== tb/sv/sparse_set_active_partition_tb.sv =====
// self-checking testbench of the sparse set active partition
`timescale 1ns / 1ps

module sparse_set_active_partition_tb;

  localparam int unsigned ARCS        = ssap_pkg::MAX_ARCS_DEF;
  localparam int unsigned CYCLE_LIMIT = 800_000;

  // command codes the block ignores: reported like a query, but never flagged as a bad index
  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  typedef struct packed {
    logic       is_active;
    logic [6:0] active_count;
    logic       bad_index;
  } status_t;

  // tracks the committed and tentative permutation and the status each command returns
  class partition_tracker;
    int unsigned arc_limit;
    bit [5:0]    pos_com [ARCS];
    bit [5:0]    pos_tent [ARCS];
    bit [31:0]   pos_ts [ARCS];
    bit          pos_has [ARCS];
    bit [5:0]    arc_com [ARCS];
    bit [5:0]    arc_tent [ARCS];
    bit [31:0]   arc_ts [ARCS];
    bit          arc_has [ARCS];
    bit [6:0]    cnt_com;
    bit [6:0]    cnt_tent;
    bit [31:0]   cnt_ts;
    bit          cnt_has;
    status_t     expected_status [$];
    int unsigned mismatches;

    function new();
      arc_limit = ssap_pkg::ARC_COUNT_RESET;
      for (int i = 0; i < ARCS; i++) begin
        pos_com[i] = i[5:0];
        arc_com[i] = i[5:0];
        pos_has[i] = 1'b0;
        arc_has[i] = 1'b0;
      end
      cnt_com    = '0;
      cnt_has    = 1'b0;
      mismatches = 0;
    endfunction

    function bit [5:0] pos_rd(bit [31:0] stamp, bit [5:0] arc);
      return (pos_has[arc] && pos_ts[arc] == stamp) ? pos_tent[arc] : pos_com[arc];
    endfunction

    function void pos_wr(bit [31:0] stamp, bit [5:0] arc, bit [5:0] slot);
      pos_tent[arc] = slot;
      pos_ts[arc]   = stamp;
      pos_has[arc]  = 1'b1;
    endfunction

    function bit [5:0] arc_rd(bit [31:0] stamp, bit [5:0] slot);
      return (arc_has[slot] && arc_ts[slot] == stamp) ? arc_tent[slot] : arc_com[slot];
    endfunction

    function void arc_wr(bit [31:0] stamp, bit [5:0] slot, bit [5:0] arc);
      arc_tent[slot] = arc;
      arc_ts[slot]   = stamp;
      arc_has[slot]  = 1'b1;
    endfunction

    function bit [6:0] cnt_rd(bit [31:0] stamp);
      return (cnt_has && cnt_ts == stamp) ? cnt_tent : cnt_com;
    endfunction

    function void cnt_wr(bit [31:0] stamp, int unsigned value);
      cnt_tent = (value > ARCS) ? 7'(ARCS) : 7'(value);
      cnt_ts   = stamp;
      cnt_has  = 1'b1;
    endfunction

    // swap the arc into the slot that sits at the current count
    function void swap_to_boundary(bit [31:0] stamp, bit [5:0] arc);
      bit [5:0] pa;
      bit [6:0] pb;
      bit [5:0] other;
      pa = pos_rd(stamp, arc);
      pb = cnt_rd(stamp);
      if ({1'b0, pa} == pb || pb >= ARCS) return;
      other = arc_rd(stamp, pb[5:0]);
      arc_wr(stamp, pa, other);
      arc_wr(stamp, pb[5:0], arc);
      pos_wr(stamp, arc, pb[5:0]);
      pos_wr(stamp, other, pa);
    endfunction

    function int unsigned pending();
      return expected_status.size();
    endfunction

    function void take_command(logic [2:0] op, logic [5:0] arc, logic [31:0] stamp);
      bit       in_range;
      bit       flag;
      bit [6:0] c;
      status_t  want;
      in_range = arc < arc_limit;
      flag     = 1'b0;
      if ((op == ssap_pkg::CMD_QUERY || op == ssap_pkg::CMD_ACTIVATE ||
           op == ssap_pkg::CMD_DEACTIVATE) && !in_range) begin
        flag = 1'b1;
      end else begin
        case (op)
          ssap_pkg::CMD_ACTIVATE: begin
            c = cnt_rd(stamp);
            if ({1'b0, pos_rd(stamp, arc)} >= c) begin
              swap_to_boundary(stamp, arc);
              cnt_wr(stamp, c + 1);
            end
          end
          ssap_pkg::CMD_DEACTIVATE: begin
            c = cnt_rd(stamp);
            if ({1'b0, pos_rd(stamp, arc)} < c && c > 0) begin
              cnt_wr(stamp, c - 1);
              swap_to_boundary(stamp, arc);
            end
          end
          ssap_pkg::CMD_CLEAR_ALL: cnt_wr(stamp, 0);
          ssap_pkg::CMD_COMMIT: begin
            for (int i = 0; i < ARCS; i++) begin
              if (arc_has[i] && arc_ts[i] == stamp) arc_com[i] = arc_tent[i];
              if (pos_has[i] && pos_ts[i] == stamp) pos_com[i] = pos_tent[i];
            end
            if (cnt_has && cnt_ts == stamp) cnt_com = cnt_tent;
          end
          default: ;
        endcase
      end
      want.is_active    = in_range && ({1'b0, pos_rd(stamp, arc)} < cnt_rd(stamp));
      want.active_count = cnt_rd(stamp);
      want.bad_index    = flag;
      expected_status   = {expected_status, want};
    endfunction

    function void check_response(logic [7:0] data, logic user);
      status_t want;
      if (expected_status.size() == 0) begin
        $error("status with no command pending: tdata %h tuser %b", data, user);
        mismatches++;
        return;
      end
      want = expected_status.pop_front();
      if (data[0] !== want.is_active) begin
        $error("is_active: expected %0d, actual %0d", want.is_active, data[0]);
        mismatches++;
      end
      if (data[7:1] !== want.active_count) begin
        $error("active_count: expected %0d, actual %0d", want.active_count, data[7:1]);
        mismatches++;
      end
      if (user !== want.bad_index) begin
        $error("bad_index: expected %0d, actual %0d", want.bad_index, user);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic [47:0] s_tdata     = '0;
  logic        s_tvalid    = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_tready    = 1'b0;
  logic        cfg_we      = 1'b0;
  logic [6:0]  cfg_wdata   = '0;

  partition_tracker tracker;
  int unsigned      tx_idle_pct  = 0;
  int unsigned      rx_stall_pct = 0;
  int unsigned      arc_cfg      = ssap_pkg::ARC_COUNT_RESET;
  int unsigned      sent_items   = 0;
  int unsigned      cycle_count;
  logic [31:0]      last_stamp   = '0;

  sparse_set_active_partition dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_tdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // status side: random backpressure, compare every transaction
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_tready) tracker.check_response(m_axis_tdata, m_axis_tuser);
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk_i);
    $display("** sparse_set_active_partition: FAILED **");
    $finish;
  end

  task automatic send_cmd(logic [2:0] op, logic [5:0] arc, logic [31:0] stamp);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, stamp, arc, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.take_command(op, arc, stamp);
    sent_items++;
  endtask

  // hold the command side until every status is back
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_arc_count(int unsigned value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[6:0];
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    arc_cfg           = (value > ARCS) ? ARCS : value;
    tracker.arc_limit = arc_cfg;
    @(posedge clk_i);
  endtask

  function automatic logic [5:0] pick_arc();
    if (arc_cfg > 0 && $urandom_range(9) != 0) return 6'($urandom_range(arc_cfg - 1));
    return 6'($urandom_range(63));
  endfunction

  // reusing an old stamp exposes tentative entries left over from earlier runs
  function automatic logic [31:0] pick_stamp();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) last_stamp = $urandom;
    else if (r < 85 && r >= 70) last_stamp = $urandom_range(3);
    else if (r >= 85) last_stamp = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    return last_stamp;
  endfunction

  task automatic run_random(int unsigned quota);
    int unsigned goal;
    int unsigned r;
    int unsigned len;
    logic [31:0] stamp;
    logic [2:0]  op;
    goal = sent_items + quota;
    while (sent_items < goal) begin
      r = $urandom_range(99);
      if (r < 3) begin
        wait_quiet();
      end else if (r < 82) begin
        // one transaction group: tentative edits under a stamp, then mostly a commit
        stamp = pick_stamp();
        len   = $urandom_range(12, 2);
        repeat (len) begin
          r = $urandom_range(99);
          if (r < 40) send_cmd(ssap_pkg::CMD_ACTIVATE, pick_arc(), stamp);
          else if (r < 65) send_cmd(ssap_pkg::CMD_DEACTIVATE, pick_arc(), stamp);
          else if (r < 85) send_cmd(ssap_pkg::CMD_QUERY, pick_arc(), stamp);
          else if (r < 90) send_cmd(ssap_pkg::CMD_CLEAR_ALL, pick_arc(), stamp);
          else send_cmd(ssap_pkg::CMD_QUERY, pick_arc(), $urandom);
        end
        r = $urandom_range(99);
        if (r < 75) send_cmd(ssap_pkg::CMD_COMMIT, pick_arc(), stamp);
        else if (r < 85) send_cmd(ssap_pkg::CMD_COMMIT, pick_arc(), pick_stamp());
      end else begin
        op    = 3'($urandom_range(7));
        stamp = $urandom_range(1) ? last_stamp : 32'($urandom);
        send_cmd(op, 6'($urandom_range(63)), stamp);
      end
    end
  endtask

  initial begin
    int unsigned arc_settings [8];
    arc_settings = '{127, 0, 1, 2, 37, 63, 64, 100};
    tracker = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset view, tentative vs committed view, repeats, clear, commit, reserved codes
    send_cmd(ssap_pkg::CMD_QUERY, 6'd0, 32'h0);
    send_cmd(ssap_pkg::CMD_ACTIVATE, 6'd63, 32'h0);
    send_cmd(ssap_pkg::CMD_QUERY, 6'd63, 32'h5);
    send_cmd(ssap_pkg::CMD_ACTIVATE, 6'd0, 32'h0);
    send_cmd(ssap_pkg::CMD_ACTIVATE, 6'd0, 32'h0);
    send_cmd(ssap_pkg::CMD_DEACTIVATE, 6'd63, 32'h0);
    send_cmd(ssap_pkg::CMD_DEACTIVATE, 6'd63, 32'h0);
    send_cmd(ssap_pkg::CMD_CLEAR_ALL, 6'd17, 32'h0);
    send_cmd(ssap_pkg::CMD_ACTIVATE, 6'd5, 32'h0);
    send_cmd(ssap_pkg::CMD_ACTIVATE, 6'd6, 32'h0);
    send_cmd(ssap_pkg::CMD_COMMIT, 6'd5, 32'h0);
    send_cmd(ssap_pkg::CMD_QUERY, 6'd6, 32'hFFFF_FFFF);
    send_cmd(CMD_RSVD5, 6'd6, 32'h0);
    send_cmd(CMD_RSVD6, 6'd63, 32'hFFFF_FFFF);
    send_cmd(CMD_RSVD7, 6'd0, 32'hAAAA_5555);
    send_cmd(ssap_pkg::CMD_ACTIVATE, 6'd42, 32'hFFFF_FFFF);
    send_cmd(ssap_pkg::CMD_DEACTIVATE, 6'd5, 32'hFFFF_FFFF);
    send_cmd(ssap_pkg::CMD_COMMIT, 6'd63, 32'hFFFF_FFFF);
    wait_quiet();
    // shrink the arc range: permutation stays, only the range check moves
    write_arc_count(10);
    send_cmd(ssap_pkg::CMD_QUERY, 6'd10, 32'h0);
    send_cmd(ssap_pkg::CMD_ACTIVATE, 6'd63, 32'h0);
    send_cmd(ssap_pkg::CMD_DEACTIVATE, 6'd12, 32'h0);
    send_cmd(ssap_pkg::CMD_CLEAR_ALL, 6'd63, 32'h1);
    send_cmd(ssap_pkg::CMD_QUERY, 6'd9, 32'hFFFF_FFFF);
    send_cmd(ssap_pkg::CMD_COMMIT, 6'd40, 32'h1);

    for (int p = 0; p < 8; p++) begin
      wait_quiet();
      write_arc_count(arc_settings[p]);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 76; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 76; end
        default: begin tx_idle_pct = 36; rx_stall_pct = 36; end
      endcase
      run_random(190);
    end

    wait_quiet();
    repeat (12) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("** sparse_set_active_partition: PASSED **");
    end else begin
      $display("** sparse_set_active_partition: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ssap_pkg.sv
rtl/core/ssap_table.sv
rtl/core/sparse_set_active_partition.sv
tb/sv/sparse_set_active_partition_tb.sv
